// ===== hw/rtl/mrir_pkg.sv =====
// Shared types, constants and helpers for the minimal standard random generator.
`timescale 1ns / 1ps

package mrir_pkg;

   localparam int SEED_W    = 31;
   localparam int AMOUNT_W  = 16;
   localparam int MULT_W    = 15;
   localparam int PROD_W    = SEED_W + MULT_W;
   localparam int DIV_STEPS = SEED_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
   localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
   localparam logic [SEED_W-1:0] SEED_MAX = 31'h7FFF_FFFE;
   localparam logic [SEED_W-1:0] SEED_MIN = 31'd1;
   localparam logic [SEED_W-1:0] SEED_RST = 31'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FOLD,
      ST_DIV,
      ST_DONE
   } mrir_state_type;

   typedef struct packed {
      logic ld_req;
      logic mul;
      logic fold;
      logic div_step;
      logic ld_rsp;
   } mrir_cmd_type;

   typedef struct packed {
      logic req_zero;
   } mrir_status_type;

   function automatic logic [SEED_W-1:0] clamp_seed(input logic [SEED_W-1:0] s);
      logic [SEED_W-1:0] r;
      r = s;
      if (s == '0) begin
         r = SEED_MIN;
      end else if (s > SEED_MAX) begin
         r = SEED_MAX;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/minstd_random_in_range_top.sv =====
// Top level of the minimal standard random generator with a range bound.
//
//   Channel | Direction | Ports                                   | Beat
//   req     | in        | req_valid, req_stall, req_amount        | one bound per beat
//   rsp     | out       | rsp_valid, rsp_stall, rsp_value,        | one result per beat
//           |           | rsp_bad_amount                          |
//   csr     | in        | csr_wr_en, csr_wr_data                  | loads the seed
//
// A request with a nonzero amount goes from acceptance to the result register through
// a multiply step, a fold step, the one-bit-per-cycle remainder unit and a hand-off
// step that waits until the result register is free.
// A zero amount goes straight to the hand-off step and leaves the seed untouched.
// The output register lets a new request be accepted while a result beat still waits.
// Reset is synchronous and sets the seed to 1; the result register comes up empty.
`timescale 1ns / 1ps

module minstd_random_in_range_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mrir_pkg::AMOUNT_W-1:0] req_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mrir_pkg::AMOUNT_W-1:0] rsp_value,
   output logic                          rsp_bad_amount,
   input  logic                          csr_wr_en,
   input  logic [mrir_pkg::SEED_W-1:0]   csr_wr_data
);
   import mrir_pkg::*;

   mrir_cmd_type    cmd;
   mrir_status_type status;
   logic [SEED_W-1:0] seed_wr_data;

   // Reset loads the seed through the same path as a register write.
   assign seed_wr_data = reset ? SEED_RST : csr_wr_data;

   mrir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mrir_dp u_dp (
      .clock          (clock),
      .req_amount     (req_amount),
      .csr_wr_en      (csr_wr_en | reset),
      .csr_wr_data    (seed_wr_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_value      (rsp_value),
      .rsp_bad_amount (rsp_bad_amount)
   );

endmodule

// ===== hw/rtl/mrir_ctrl.sv =====
// Controller state machine: sequences multiply, fold, division and result hand-off.
`timescale 1ns / 1ps

module mrir_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  mrir_pkg::mrir_status_type status,
   output mrir_pkg::mrir_cmd_type   cmd
);
   import mrir_pkg::*;

   mrir_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = status.req_zero ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.ld_rsp = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.ld_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/mrir_dp.sv =====
// Datapath: seed register, multiply and Mersenne fold, restoring remainder unit, result register.
`timescale 1ns / 1ps

module mrir_dp (
   input  logic                                clock,
   input  logic [mrir_pkg::AMOUNT_W-1:0]       req_amount,
   input  logic                                csr_wr_en,
   input  logic [mrir_pkg::SEED_W-1:0]         csr_wr_data,
   input  mrir_pkg::mrir_cmd_type              cmd,
   output mrir_pkg::mrir_status_type           status,
   output logic [mrir_pkg::AMOUNT_W-1:0]       rsp_value,
   output logic                                rsp_bad_amount
);
   import mrir_pkg::*;

   logic [SEED_W-1:0]   seed_ff, seed_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [AMOUNT_W-1:0] amount_ff;
   logic                bad_ff;
   logic [SEED_W-1:0]   div_ff, div_in;
   logic [AMOUNT_W-1:0] rem_ff, rem_in;
   logic [AMOUNT_W-1:0] value_ff;
   logic                bad_out_ff;
   logic [SEED_W:0]     fold_sum;
   logic [SEED_W-1:0]   fold_res;
   logic [AMOUNT_W:0]   trial;

   assign status.req_zero = (req_amount == '0);

   assign prod_in = {{MULT_W{1'b0}}, seed_ff} * {{SEED_W{1'b0}}, LCG_MULT};

   // Since 2^31 == 1 modulo the Mersenne prime, the high part adds onto the low part.
   always_comb begin
      fold_sum = {1'b0, prod_ff[SEED_W-1:0]}
               + {{(SEED_W + 1 - MULT_W){1'b0}}, prod_ff[PROD_W-1:SEED_W]};
      if (fold_sum >= {1'b0, LCG_MOD}) begin
         fold_res = SEED_W'(fold_sum - {1'b0, LCG_MOD});
      end else begin
         fold_res = fold_sum[SEED_W-1:0];
      end
   end

   always_comb begin
      seed_in = seed_ff;
      if (csr_wr_en) begin
         seed_in = clamp_seed(csr_wr_data);
      end else if (cmd.fold) begin
         seed_in = fold_res;
      end
   end

   // One quotient bit per cycle; the remainder stays below the amount.
   always_comb begin
      trial  = {rem_ff, div_ff[SEED_W-1]};
      div_in = {div_ff[SEED_W-2:0], 1'b0};
      if (trial >= {1'b0, amount_ff}) begin
         rem_in = AMOUNT_W'(trial - {1'b0, amount_ff});
      end else begin
         rem_in = trial[AMOUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         amount_ff <= req_amount;
         bad_ff    <= status.req_zero;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.fold) begin
         div_ff <= fold_res;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
      if (cmd.ld_rsp) begin
         value_ff   <= bad_ff ? '0 : rem_ff;
         bad_out_ff <= bad_ff;
      end
   end

   assign rsp_value      = value_ff;
   assign rsp_bad_amount = bad_out_ff;

endmodule

// ===== hw/rtl/mrir_chk.sv =====
// Port-level checker for the random generator top level, with its bind.
`timescale 1ns / 1ps

module mrir_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [mrir_pkg::AMOUNT_W-1:0] rsp_value,
   input logic                          rsp_bad_amount
);

   // The result register comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // A flagged zero amount always returns a zero value.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_amount) |-> (rsp_value == '0))
      else $error("bad amount result with nonzero value");

   // Only one item is in flight: the request side closes right after a beat.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous item still in work");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_value)
                                    && $stable(rsp_bad_amount)))
      else $error("stalled result beat changed");

endmodule

bind minstd_random_in_range_top mrir_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_value      (rsp_value),
   .rsp_bad_amount (rsp_bad_amount)
);
